FILE: design/ptcm_pkg.sv
// Shared types, constants and microcode for the palette tolerance colour match core.
`default_nettype none
package ptcm_pkg;

  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned THR_W     = 7;
  localparam int unsigned MIDX_W    = 9;
  localparam int unsigned ENTRY_W   = 3 * CHAN_W;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 32;

  localparam logic [MIDX_W-1:0] NO_MATCH_INDEX = MIDX_W'(256);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MATCH = 1'b1;

  localparam logic [THR_W-1:0] FINE_RESET   = THR_W'(1);
  localparam logic [THR_W-1:0] COARSE_RESET = THR_W'(10);

  // register index is paddr[2]
  typedef enum logic {
    REG_FINE   = 1'b0,
    REG_COARSE = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_START,
    STEP_SCAN,
    STEP_DRAIN,
    STEP_FINISH
  } step_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_MATCH_BEAT,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic  accept_en;
    logic  start_en;
    logic  read_en;
    logic  finish_en;
    cond_t cond;
    step_t jump_step;
    step_t next_step;
  } uword_t;

  // Control store: one word per step; jump when cond holds, else fall through.
  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_FETCH: begin
        w.accept_en = 1'b1;
        w.cond      = COND_NO_MATCH_BEAT;
        w.jump_step = STEP_FETCH;
        w.next_step = STEP_START;
      end
      STEP_START: begin
        w.start_en  = 1'b1;
        w.cond      = COND_NEVER;
        w.jump_step = STEP_FETCH;
        w.next_step = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.read_en   = 1'b1;
        w.cond      = COND_SCAN_MORE;
        w.jump_step = STEP_SCAN;
        w.next_step = STEP_DRAIN;
      end
      STEP_DRAIN: begin
        w.cond      = COND_NEVER;
        w.jump_step = STEP_FETCH;
        w.next_step = STEP_FINISH;
      end
      STEP_FINISH: begin
        w.finish_en = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.jump_step = STEP_FINISH;
        w.next_step = STEP_FETCH;
      end
      default: begin
        w.cond      = COND_NEVER;
        w.jump_step = STEP_FETCH;
        w.next_step = STEP_FETCH;
      end
    endcase
    return w;
  endfunction

  // round(v*100/255) = floor((200v+255)/510) = floor(y/255), y = (200v+255)>>1
  function automatic logic [PCT_W-1:0] to_percent(logic [CHAN_W-1:0] v);
    logic [15:0] x;
    logic [14:0] y;
    logic [14:0] s;
    x = 16'(v) * 16'd200 + 16'd255;
    y = x[15:1];
    s = y + 15'd1 + 15'(y[14:8]);
    return s[14:8];
  endfunction

  function automatic logic [PCT_W-1:0] abs_diff(logic [PCT_W-1:0] a, logic [PCT_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

FILE: design/ptcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ptcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/palette_tolerance_color_match_core.sv
// Top level: palette store with microcoded two-threshold colour match scan.
`default_nettype none
// Usage
//   Input channel (in_valid / in_stall) carries one beat per command. A write
//   beat (command 0) stores red/green/blue at entry_index; indexes at or above
//   PALETTE_ENTRIES are dropped. A write yields no result.
//   A match beat (command 1) scans every palette entry, one entry per cycle out
//   of the RAM read port, checking the fine and coarse thresholds side by side.
//   Result channel (out_valid / out_stall) carries one beat per match:
//   match_index is the highest entry within the fine threshold, else the
//   highest within the coarse threshold, else 256 with found low.
//   Once a match beat is taken the sequencer runs its start, scan, drain and
//   finish steps, stalling the input; out_valid rises when finish loads the
//   result. Thresholds sit on the APB port (fine at 0x0, coarse at 0x4); the
//   user must write them only while idle, as the block does not enforce it.
//   Reset clears the sequencer and the result valid flag and sets the thresholds
//   (fine 1, coarse 10); palette entries stay undefined until written.
//   A stalled result holds in the output register; the sequencer still takes
//   and scans the next beat, then waits in its last step until the register frees.
module palette_tolerance_color_match_core import ptcm_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_command,
  input  wire logic [7:0]        in_entry_index,
  input  wire logic [7:0]        in_red,
  input  wire logic [7:0]        in_green,
  input  wire logic [7:0]        in_blue,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [MIDX_W-1:0]      out_match_index,
  output logic                   out_found,
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);

  // sequencer
  step_t  step_r, step_nxt;
  uword_t uw;
  logic   jump_take;

  // datapath registers
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic [PCT_W-1:0]  q_red_r, q_red_nxt;
  logic [PCT_W-1:0]  q_green_r, q_green_nxt;
  logic [PCT_W-1:0]  q_blue_r, q_blue_nxt;
  logic              fine_hit_r, fine_hit_nxt;
  logic              coarse_hit_r, coarse_hit_nxt;
  logic [MIDX_W-1:0] fine_idx_r, fine_idx_nxt;
  logic [MIDX_W-1:0] coarse_idx_r, coarse_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic              out_found_r, out_found_nxt;
  logic [THR_W-1:0]  fine_thr_r, fine_thr_nxt;
  logic [THR_W-1:0]  coarse_thr_r, coarse_thr_nxt;

  // combinational helpers
  logic              in_beat;
  logic              out_busy;
  logic              finish_load;
  logic              cfg_write;
  logic [AW+7:0]     widx_ext;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [PCT_W-1:0]  d_red, d_green, d_blue;
  logic              fine_ok, coarse_ok;
  logic [AW+MIDX_W-1:0] cmp_idx_ext;

  assign uw        = ucode_rom(step_r);
  assign in_stall  = !uw.accept_en;
  assign in_beat   = in_valid && uw.accept_en;
  assign out_busy  = out_valid_r && out_stall;
  assign finish_load = uw.finish_en && !out_busy;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  // palette write address; drop indexes past the end of the palette
  assign widx_ext  = {{AW{1'b0}}, in_entry_index};
  assign ram_waddr = widx_ext[AW-1:0];
  assign ram_we    = in_beat && (in_command == CMD_WRITE) &&
                     (widx_ext < (AW+8)'(PALETTE_ENTRIES));

  ptcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_red, in_green, in_blue}),
    .re    (uw.read_en),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // entry under test against both thresholds
  assign d_red   = abs_diff(to_percent(ram_rdata[23:16]), q_red_r);
  assign d_green = abs_diff(to_percent(ram_rdata[15:8]),  q_green_r);
  assign d_blue  = abs_diff(to_percent(ram_rdata[7:0]),   q_blue_r);
  assign fine_ok   = (d_red <= fine_thr_r) && (d_green <= fine_thr_r) &&
                     (d_blue <= fine_thr_r);
  assign coarse_ok = (d_red <= coarse_thr_r) && (d_green <= coarse_thr_r) &&
                     (d_blue <= coarse_thr_r);
  assign cmp_idx_ext = {{MIDX_W{1'b0}}, cmp_idx_r};

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:         jump_take = 1'b0;
      COND_NO_MATCH_BEAT: jump_take = !(in_beat && (in_command == CMD_MATCH));
      COND_SCAN_MORE:     jump_take = (ptr_r != LAST_ENTRY);
      COND_OUT_BUSY:      jump_take = out_busy;
      default:            jump_take = 1'b0;
    endcase
  end

  always_comb begin
    step_nxt       = jump_take ? uw.jump_step : uw.next_step;
    ptr_nxt        = ptr_r;
    cmp_idx_nxt    = ptr_r;
    cmp_valid_nxt  = uw.read_en;
    q_red_nxt      = q_red_r;
    q_green_nxt    = q_green_r;
    q_blue_nxt     = q_blue_r;
    fine_hit_nxt   = fine_hit_r;
    coarse_hit_nxt = coarse_hit_r;
    fine_idx_nxt   = fine_idx_r;
    coarse_idx_nxt = coarse_idx_r;
    out_valid_nxt  = out_valid_r;
    out_idx_nxt    = out_idx_r;
    out_found_nxt  = out_found_r;
    fine_thr_nxt   = fine_thr_r;
    coarse_thr_nxt = coarse_thr_r;

    // latch the query in percent on a match beat
    if (in_beat && (in_command == CMD_MATCH)) begin
      q_red_nxt   = to_percent(in_red);
      q_green_nxt = to_percent(in_green);
      q_blue_nxt  = to_percent(in_blue);
    end

    if (uw.start_en) begin
      ptr_nxt        = '0;
      fine_hit_nxt   = 1'b0;
      coarse_hit_nxt = 1'b0;
    end

    if (uw.read_en) begin
      ptr_nxt = ptr_r + AW'(1);
    end

    // later hits overwrite earlier ones: keep the highest index
    if (cmp_valid_r) begin
      if (fine_ok) begin
        fine_hit_nxt = 1'b1;
        fine_idx_nxt = cmp_idx_ext[MIDX_W-1:0];
      end
      if (coarse_ok) begin
        coarse_hit_nxt = 1'b1;
        coarse_idx_nxt = cmp_idx_ext[MIDX_W-1:0];
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish_load) begin
      out_valid_nxt = 1'b1;
      if (fine_hit_r) begin
        out_idx_nxt   = fine_idx_r;
        out_found_nxt = 1'b1;
      end else if (coarse_hit_r) begin
        out_idx_nxt   = coarse_idx_r;
        out_found_nxt = 1'b1;
      end else begin
        out_idx_nxt   = NO_MATCH_INDEX;
        out_found_nxt = 1'b0;
      end
    end

    if (cfg_write) begin
      unique case (reg_idx_t'(cfg_paddr[2]))
        REG_FINE:   fine_thr_nxt   = cfg_pwdata[THR_W-1:0];
        REG_COARSE: coarse_thr_nxt = cfg_pwdata[THR_W-1:0];
        default:    fine_thr_nxt   = fine_thr_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_paddr[2]))
      REG_FINE:   cfg_prdata = CFG_DW'(fine_thr_r);
      REG_COARSE: cfg_prdata = CFG_DW'(coarse_thr_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= STEP_FETCH;
      cmp_valid_r  <= 1'b0;
      fine_hit_r   <= 1'b0;
      coarse_hit_r <= 1'b0;
      out_valid_r  <= 1'b0;
      fine_thr_r   <= FINE_RESET;
      coarse_thr_r <= COARSE_RESET;
    end else begin
      step_r       <= step_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      fine_hit_r   <= fine_hit_nxt;
      coarse_hit_r <= coarse_hit_nxt;
      out_valid_r  <= out_valid_nxt;
      fine_thr_r   <= fine_thr_nxt;
      coarse_thr_r <= coarse_thr_nxt;
    end
    ptr_r        <= ptr_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    q_red_r      <= q_red_nxt;
    q_green_r    <= q_green_nxt;
    q_blue_r     <= q_blue_nxt;
    fine_idx_r   <= fine_idx_nxt;
    coarse_idx_r <= coarse_idx_nxt;
    out_idx_r    <= out_idx_nxt;
    out_found_r  <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;
  assign out_found       = out_found_r;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the palette tolerance colour match core.
`timescale 1ns / 1ps
module tb_top;
  import ptcm_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  localparam int SETTLE_CYCLES   = PALETTE_ENTRIES + 8;
  localparam int RANDOM_PHASES   = 9;
  localparam int BEATS_PER_PHASE = 135;

  typedef struct packed {
    logic       command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } palette_beat_t;

  typedef struct packed {
    logic [MIDX_W-1:0] match_index;
    logic              found;
  } match_result_t;

  // Clock, reset and every block input start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_command = CMD_WRITE;
  logic [7:0]        in_entry_index = '0;
  logic [7:0]        in_red = '0;
  logic [7:0]        in_green = '0;
  logic [7:0]        in_blue = '0;
  logic              in_stall;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [MIDX_W-1:0] out_match_index;
  logic              out_found;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  palette_tolerance_color_match_core #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_entry_index (in_entry_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_match_index(out_match_index),
    .out_found      (out_found),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus side: beats waiting for the driver, and the palette as the
  // generator will have left it once every queued beat has gone in.
  palette_beat_t pending_beats[$];
  logic [23:0]   palette_plan [PALETTE_ENTRIES];
  int unsigned   beats_queued = 0;

  // Predictor side: palette and thresholds as the block should hold them,
  // and the results still owed by the block, oldest first.
  logic [23:0]       palette_model [PALETTE_ENTRIES];
  logic [THR_W-1:0]  fine_thr = FINE_RESET;
  logic [THR_W-1:0]  coarse_thr = COARSE_RESET;
  match_result_t     expected_matches[$];

  int unsigned beats_accepted = 0;
  int unsigned writes_seen = 0;
  int unsigned queries_seen = 0;
  int unsigned fine_hits = 0;
  int unsigned coarse_hits = 0;
  int unsigned no_hits = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Whole percent of one 8-bit channel, rounded to nearest.
  function automatic int percent_of(input logic [7:0] v);
    return (200 * int'(v) + 255) / 510;
  endfunction

  // Scan the whole palette once, checking both tolerances side by side;
  // the fine pass wins whenever it accepts anything, and within a pass the
  // highest accepted entry wins.
  function automatic match_result_t colour_match_lookup(input logic [7:0] r,
                                                         input logic [7:0] g,
                                                         input logic [7:0] b);
    match_result_t res;
    int qr, qg, qb, dr, dg, db, worst;
    int fine_at, coarse_at;
    qr = percent_of(r);
    qg = percent_of(g);
    qb = percent_of(b);
    fine_at = -1;
    coarse_at = -1;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      dr = percent_of(palette_model[i][23:16]) - qr;
      dg = percent_of(palette_model[i][15:8]) - qg;
      db = percent_of(palette_model[i][7:0]) - qb;
      worst = (dr < 0) ? -dr : dr;
      if (dg > worst) worst = dg;
      if (-dg > worst) worst = -dg;
      if (db > worst) worst = db;
      if (-db > worst) worst = -db;
      if (worst <= int'(fine_thr)) fine_at = i;
      if (worst <= int'(coarse_thr)) coarse_at = i;
    end
    if (fine_at >= 0) begin
      res.match_index = MIDX_W'(fine_at);
      res.found = 1'b1;
      fine_hits++;
    end else if (coarse_at >= 0) begin
      res.match_index = MIDX_W'(coarse_at);
      res.found = 1'b1;
      coarse_hits++;
    end else begin
      res.match_index = NO_MATCH_INDEX;
      res.found = 1'b0;
      no_hits++;
    end
    return res;
  endfunction

  // Queue one beat for the driver and keep the generator's palette view current.
  task automatic queue_beat(input logic command, input logic [7:0] idx,
                            input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    palette_beat_t beat;
    beat.command = command;
    beat.entry_index = idx;
    beat.red = r;
    beat.green = g;
    beat.blue = b;
    if (command == CMD_WRITE)
      palette_plan[idx] = {r, g, b};
    pending_beats.insert(pending_beats.size(), beat);
    beats_queued++;
  endtask

  // Write one threshold over the APB port, then read it back. The high bits
  // of the write data are sometimes junk: only the low THR_W bits count.
  task automatic set_threshold(input reg_idx_t which, input logic [THR_W-1:0] thr);
    logic [CFG_DW-1:0] wdata;
    logic [THR_W-1:0]  seen;
    wdata = ($urandom_range(0, 1) != 0) ? ($urandom() & ~CFG_DW'(7'h7F)) : '0;
    wdata = wdata | CFG_DW'(thr);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({which, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (which == REG_FINE)
      fine_thr = thr;
    else
      coarse_thr = thr;
    // back-to-back read of the same register
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    seen = cfg_prdata[THR_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (seen !== thr)
      note_mismatch($sformatf("%s readback: expected %0d, got %0d",
                              which.name(), thr, seen));
  endtask

  // Hold until every queued beat is in and every owed result is out, then
  // let the block finish whatever write it may still be chewing on.
  task automatic wait_drained();
    while (beats_accepted != beats_queued || expected_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input driver: bursts of random length separated by random gaps. A gap
  // is now and then long enough to straddle a whole palette scan, and some
  // bursts come with no gap at all.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_pick;
  palette_beat_t next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // the slot is free: either nothing was offered or the beat just went in
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        next_beat = pending_beats.pop_front();
        in_command     <= next_beat.command;
        in_entry_index <= next_beat.entry_index;
        in_red         <= next_beat.red;
        in_green       <= next_beat.green;
        in_blue        <= next_beat.blue;
        in_valid       <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_pick = $urandom_range(0, 9);
          gap_left <= (gap_pick < 3) ? 0 :
                      (gap_pick < 7) ? $urandom_range(1, 4) :
                      (gap_pick < 9) ? $urandom_range(5, 20) :
                                       $urandom_range(50, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern: short stalls, rare stalls longer than a full scan
  // so that the next result has to wait in the block, and long free runs.
  int unsigned stall_left = 0;
  int unsigned stall_pick;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = $urandom_range(0, 9);
      if (stall_pick < 3) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 30);
      end else if (stall_pick == 3) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(250, 700);
      end else if (stall_pick < 7) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 20);
      end else begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(100, 600);
      end
    end
  end

  // Monitor: advance the predictor on every accepted input beat and check
  // every accepted result beat against the oldest expectation.
  always @(posedge clk) begin : monitor
    match_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        beats_accepted++;
        if (in_command == CMD_WRITE) begin
          writes_seen++;
          palette_model[in_entry_index] = {in_red, in_green, in_blue};
        end else begin
          queries_seen++;
          expected_matches.insert(expected_matches.size(),
                                  colour_match_lookup(in_red, in_green, in_blue));
        end
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_matches.size() == 0) begin
          note_mismatch($sformatf("result beat with nothing owed: index %0d found %0d",
                                  out_match_index, out_found));
        end else begin
          want = expected_matches.pop_front();
          if (out_match_index !== want.match_index)
            note_mismatch($sformatf("match_index: expected %0d, got %0d",
                                    want.match_index, out_match_index));
          if (out_found !== want.found)
            note_mismatch($sformatf("found: expected %0d, got %0d",
                                    want.found, out_found));
        end
      end
    end
  end

  // Threshold settings for the random phases, extremes and out-of-range
  // values included; the last one puts the reset values back.
  logic [THR_W-1:0] phase_fine   [RANDOM_PHASES] = '{0, 0, 2,  6, 100, 127,   0, 101, 1};
  logic [THR_W-1:0] phase_coarse [RANDOM_PHASES] = '{0, 4, 15, 6, 100,   0, 127,  30, 10};

  initial begin : stimulus
    logic [7:0] chan [3];
    logic [23:0] base;
    int pick, spread, v;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every entry first, so that no scan ever touches an unwritten one.
    for (int i = 0; i < PALETTE_ENTRIES; i++)
      queue_beat(CMD_WRITE, 8'(i), 8'($urandom()), 8'($urandom()), 8'($urandom()));

    // Directed beats under the reset thresholds: primaries, black and white
    // at both ends of the palette, a duplicate colour where the higher index
    // must win, rounding neighbours and a query that only the coarse pass
    // can reach.
    queue_beat(CMD_WRITE, 8'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(CMD_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(CMD_WRITE, 8'd1,   8'hFF, 8'h00, 8'h00);
    queue_beat(CMD_WRITE, 8'd2,   8'h00, 8'hFF, 8'h00);
    queue_beat(CMD_WRITE, 8'd3,   8'h00, 8'h00, 8'hFF);
    queue_beat(CMD_WRITE, 8'd254, 8'h00, 8'h00, 8'h00);
    queue_beat(CMD_WRITE, 8'd128, 8'h80, 8'h80, 8'h80);
    queue_beat(CMD_MATCH, 8'd0,   8'h00, 8'h00, 8'h00);
    queue_beat(CMD_MATCH, 8'd255, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(CMD_MATCH, 8'd0,   8'hFF, 8'h00, 8'h00);
    queue_beat(CMD_MATCH, 8'd0,   8'h00, 8'hFF, 8'h00);
    queue_beat(CMD_MATCH, 8'd0,   8'h00, 8'h00, 8'hFF);
    queue_beat(CMD_MATCH, 8'd0,   8'h80, 8'h80, 8'h80);
    queue_beat(CMD_MATCH, 8'd0,   8'h7F, 8'h7F, 8'h7F);
    queue_beat(CMD_MATCH, 8'd0,   8'h01, 8'h01, 8'h01);
    queue_beat(CMD_MATCH, 8'd0,   8'hFE, 8'hFE, 8'hFE);
    queue_beat(CMD_MATCH, 8'd0,   8'd26, 8'd26, 8'd26);
    wait_drained();

    // Random phases, each under its own pair of thresholds.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_threshold(REG_FINE, phase_fine[p]);
      set_threshold(REG_COARSE, phase_coarse[p]);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // writes: fresh colours, corner colours, or copies of other entries
          base = palette_plan[$urandom_range(0, PALETTE_ENTRIES - 1)];
          pick = $urandom_range(0, 3);
          for (int c = 0; c < 3; c++) begin
            v = $urandom_range(0, 3);
            chan[c] = (pick == 0) ? base[16 - 8 * c +: 8] :
                      (pick == 1) ? ((v == 0) ? 8'h00 : (v == 1) ? 8'hFF :
                                     (v == 2) ? 8'h01 : 8'hFE) :
                                    8'($urandom());
          end
          queue_beat(CMD_WRITE, 8'($urandom()), chan[0], chan[1], chan[2]);
        end else begin
          // queries: half close to a stored colour, by a random spread
          base = palette_plan[$urandom_range(0, PALETTE_ENTRIES - 1)];
          pick = $urandom_range(0, 99);
          spread = ($urandom_range(0, 5) == 0) ? 0 : (1 << $urandom_range(0, 4));
          for (int c = 0; c < 3; c++) begin
            v = int'(base[16 - 8 * c +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            chan[c] = (pick < 50) ? 8'(v) :
                      (pick < 75) ? 8'($urandom()) :
                      (($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
          end
          queue_beat(CMD_MATCH, 8'($urandom()), chan[0], chan[1], chan[2]);
        end
      end
      wait_drained();
    end

    $display("Covered %0d palette writes and %0d colour queries over %0d threshold settings.",
             writes_seen, queries_seen, RANDOM_PHASES + 1);
    $display("Queries resolved: %0d in the fine pass, %0d in the coarse pass, %0d unmatched; %0d checked.",
             fine_hits, coarse_hits, no_hits, results_checked);
    if (mismatch_count == 0) begin
      $display("palette_tolerance_color_match_core: match");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("palette_tolerance_color_match_core: mismatch");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #100_000_000;
    $display("Timed out with %0d beats queued, %0d accepted, %0d results owed",
             beats_queued, beats_accepted, expected_matches.size());
    $display("palette_tolerance_color_match_core: mismatch");
    $finish;
  end

endmodule
